// ----- hdl/sorted_price_level_table_unit_macros.svh -----
// Assertion macros shared by the price level table RTL
`ifndef SORTED_PRICE_LEVEL_TABLE_UNIT_MACROS_SVH
`define SORTED_PRICE_LEVEL_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define SPTU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset
`define SPTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sptu_pkg.sv -----
// Package: sizes, request and status codes and the cell command for the price table
`default_nettype none

package sptu_pkg;

   // default sizes
   localparam int SPTU_TABLE_DEPTH = 64;
   localparam int SPTU_PRICE_BITS  = 32;

   // request kinds (the unused code behaves as a lookup)
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_CREATE = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_FOUND    = 3'd0;
   localparam logic [2:0] STATUS_MISSING  = 3'd1;
   localparam logic [2:0] STATUS_CREATED  = 3'd2;
   localparam logic [2:0] STATUS_FULL     = 3'd3;
   localparam logic [2:0] STATUS_MISMATCH = 3'd4;

   // command broadcast from the control to every cell
   typedef struct packed {
      logic compare;     // latch compare flags against the key
      logic shift_up;    // insert: cells at or above the rank move up
      logic shift_down;  // erase: cells at or above the rank pull from above
      logic new_side;    // side written with an inserted price
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- hdl/sptu_channels.sv -----
// Interfaces: request and response channels of the price level table
`default_nettype none

interface sptu_req_if
   import sptu_pkg::*;
#(
   parameter int PRICE_BITS = SPTU_PRICE_BITS
) ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [PRICE_BITS-1:0] price;
   logic                  side;

   modport source (output valid, kind, price, side, input ready);
   modport sink   (input valid, kind, price, side, output ready);
endinterface

interface sptu_rsp_if
   import sptu_pkg::*;
#(
   parameter int TABLE_DEPTH = SPTU_TABLE_DEPTH
) ();
   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);

   logic                  valid;
   logic                  ready;
   logic [2:0]            status;
   logic [COUNT_BITS-1:0] rank;
   logic                  stored_side;
   logic [COUNT_BITS-1:0] level_count;

   modport source (output valid, status, rank, stored_side, level_count, input ready);
   modport sink   (input valid, status, rank, stored_side, level_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/sorted_price_level_table_unit.sv -----
// Top level: sorted price level table built as a chain of compare-and-shift cells
//
//   channel   dir   payload                                   handshake
//   req_chan  in    kind, price, side                         valid / ready
//   rsp_chan  out   status, rank, stored_side, level_count    valid / ready
//
// After acceptance the result is built in these steps, in order, up to the output register:
// parallel compare in every cell, rank encode and decision, shift and count update.
// The cell chain serves one item at a time, so a new item is taken only once the last has left the shift step.
// A stalled output holds the item in the shift step until the output register is free.
// Synchronous reset empties the table (count zero); the cell contents need no clearing.
`default_nettype none
`include "sorted_price_level_table_unit_macros.svh"

module sorted_price_level_table_unit
   import sptu_pkg::*;
#(
   parameter int TABLE_DEPTH = SPTU_TABLE_DEPTH,
   parameter int PRICE_BITS  = SPTU_PRICE_BITS
) (
   input wire logic clock,
   input wire logic reset,
   sptu_req_if.sink   req_chan,
   sptu_rsp_if.source rsp_chan
);

   localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_RANK  = 2'd2;
   localparam logic [1:0] S_APPLY = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // captured request
   logic [1:0]            kind_ff;
   logic [PRICE_BITS-1:0] key_ff;
   logic                  side_ff;

   // decision taken in the rank step
   logic [2:0]            res_status_ff, res_status_in;
   logic [COUNT_BITS-1:0] res_rank_ff;
   logic                  res_side_ff, res_side_in;
   logic [COUNT_BITS-1:0] res_count_ff, res_count_in;
   logic                  op_insert_ff, op_insert_in;
   logic                  op_erase_ff, op_erase_in;

   // output register
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff;
   logic [COUNT_BITS-1:0] rsp_rank_ff;
   logic                  rsp_side_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic req_fire;
   logic rsp_free;
   logic apply_fire;

   // cell chain
   cell_cmd_type          cmd;
   logic [PRICE_BITS-1:0] cell_price [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] side_vec;
   logic [TABLE_DEPTH-1:0] lt_vec;
   logic [TABLE_DEPTH-1:0] eq_vec;
   logic [TABLE_DEPTH-1:0] lt_low_vec;

   logic [COUNT_BITS-1:0] rank;
   logic                  hit;
   logic                  hit_side;

   // handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign apply_fire     = (state_ff == S_APPLY) && rsp_free;

   // command to the cells
   assign cmd.compare    = (state_ff == S_CMP);
   assign cmd.shift_up   = apply_fire && op_insert_ff;
   assign cmd.shift_down = apply_fire && op_erase_ff;
   assign cmd.new_side   = side_ff;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic                  left_lt;
      logic [PRICE_BITS-1:0] left_price;
      logic                  left_side;
      logic [PRICE_BITS-1:0] right_price;
      logic                  right_side;

      if (g == 0) begin : g_first
         // the chain head sees a virtual neighbour below the key
         assign left_lt    = 1'b1;
         assign left_price = '0;
         assign left_side  = 1'b0;
      end else begin : g_mid
         assign left_lt    = lt_vec[g-1];
         assign left_price = cell_price[g-1];
         assign left_side  = side_vec[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         // beyond the last cell nothing is stored
         assign right_price = '0;
         assign right_side  = 1'b0;
      end else begin : g_inner
         assign right_price = cell_price[g+1];
         assign right_side  = side_vec[g+1];
      end

      sptu_cell #(
         .PRICE_BITS (PRICE_BITS),
         .COUNT_BITS (COUNT_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .key_price   (key_ff),
         .cmd         (cmd),
         .count       (count_ff),
         .left_lt     (left_lt),
         .left_price  (left_price),
         .left_side   (left_side),
         .right_price (right_price),
         .right_side  (right_side),
         .price       (cell_price[g]),
         .side        (side_vec[g]),
         .lt          (lt_vec[g]),
         .eq          (eq_vec[g])
      );
   end

   sptu_rank #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_rank (
      .lt_vec   (lt_vec),
      .eq_vec   (eq_vec),
      .side_vec (side_vec),
      .rank     (rank),
      .hit      (hit),
      .hit_side (hit_side)
   );

   // decision per request kind
   always_comb begin
      res_status_in = STATUS_MISSING;
      res_side_in   = 1'b0;
      res_count_in  = count_ff;
      op_insert_in  = 1'b0;
      op_erase_in   = 1'b0;
      unique case (kind_ff)
         KIND_CREATE: begin
            if (hit) begin
               res_side_in   = hit_side;
               res_status_in = (hit_side == side_ff) ? STATUS_FOUND : STATUS_MISMATCH;
            end else if (count_ff == FULL_COUNT) begin
               res_status_in = STATUS_FULL;
            end else begin
               res_status_in = STATUS_CREATED;
               res_side_in   = side_ff;
               res_count_in  = count_ff + 1'b1;
               op_insert_in  = 1'b1;
            end
         end
         KIND_ERASE: begin
            if (hit) begin
               res_status_in = STATUS_FOUND;
               res_side_in   = hit_side;
               res_count_in  = count_ff - 1'b1;
               op_erase_in   = 1'b1;
            end
         end
         default: begin
            if (hit) begin
               res_status_in = STATUS_FOUND;
               res_side_in   = hit_side;
            end
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_CMP;
         S_CMP:   state_in = S_RANK;
         S_RANK:  state_in = S_APPLY;
         S_APPLY: begin
            if (apply_fire) begin
               state_in = S_IDLE;
               count_in = res_count_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (apply_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_chan.kind;
         key_ff  <= req_chan.price;
         side_ff <= req_chan.side;
      end
   end

   // decision register
   always_ff @(posedge clock) begin
      if (state_ff == S_RANK) begin
         res_status_ff <= res_status_in;
         res_rank_ff   <= rank;
         res_side_ff   <= res_side_in;
         res_count_ff  <= res_count_in;
         op_insert_ff  <= op_insert_in;
         op_erase_ff   <= op_erase_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (apply_fire) begin
         rsp_status_ff <= res_status_ff;
         rsp_rank_ff   <= res_rank_ff;
         rsp_side_ff   <= res_side_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.rank        = rsp_rank_ff;
   assign rsp_chan.stored_side = rsp_side_ff;
   assign rsp_chan.level_count = rsp_count_ff;

   // each less-than flag above cell 0 must sit on top of another one (sorted table)
   assign lt_low_vec = {lt_vec[TABLE_DEPTH-2:0], 1'b1};

   `SPTU_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "entry count beyond table depth")
   `SPTU_ASSERT_NOW(a_single_match, clock, reset, state_ff == S_RANK, $onehot0(eq_vec), "more than one cell matches the key")
   `SPTU_ASSERT_NOW(a_sorted_run, clock, reset, state_ff == S_RANK, (lt_vec & ~lt_low_vec) == '0, "less-than flags not a run from the bottom")
   `SPTU_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == S_CMP, "accepted item did not start the compare")
   `SPTU_ASSERT_NEXT(a_count_hold, clock, reset, !apply_fire, count_ff == $past(count_ff), "entry count moved outside the shift step")

endmodule

`default_nettype wire

// ----- hdl/sptu_cell.sv -----
// One table cell: holds a price and side, compares with the key, shifts with its neighbours
`default_nettype none

module sptu_cell
   import sptu_pkg::*;
#(
   parameter int PRICE_BITS = SPTU_PRICE_BITS,
   parameter int COUNT_BITS = 7,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic [PRICE_BITS-1:0] key_price,
   input  wire cell_cmd_type          cmd,
   input  wire logic [COUNT_BITS-1:0] count,
   input  wire logic                  left_lt,
   input  wire logic [PRICE_BITS-1:0] left_price,
   input  wire logic                  left_side,
   input  wire logic [PRICE_BITS-1:0] right_price,
   input  wire logic                  right_side,
   output logic [PRICE_BITS-1:0]      price,
   output logic                       side,
   output logic                       lt,
   output logic                       eq
);

   localparam logic [COUNT_BITS-1:0] MY_INDEX = COUNT_BITS'(CELL_INDEX);

   logic [PRICE_BITS-1:0] price_ff;
   logic                  side_ff;
   logic                  lt_ff;
   logic                  eq_ff;
   logic                  occupied;

   // entries at or above the count hold nothing meaningful
   assign occupied = count > MY_INDEX;

   // compare flags, latched once per item
   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         lt_ff <= occupied && (price_ff < key_price);
         eq_ff <= occupied && (price_ff == key_price);
      end
   end

   // shift: cells below the rank keep their entry
   always_ff @(posedge clock) begin
      if (cmd.shift_up && !lt_ff) begin
         if (left_lt) begin
            price_ff <= key_price;
            side_ff  <= cmd.new_side;
         end else begin
            price_ff <= left_price;
            side_ff  <= left_side;
         end
      end else if (cmd.shift_down && !lt_ff) begin
         price_ff <= right_price;
         side_ff  <= right_side;
      end
   end

   assign price = price_ff;
   assign side  = side_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

`default_nettype wire

// ----- hdl/sptu_rank.sv -----
// Rank encoder: turns the cells' compare flags into rank, hit and matching side
`default_nettype none

module sptu_rank
   import sptu_pkg::*;
#(
   parameter int TABLE_DEPTH = SPTU_TABLE_DEPTH,
   parameter int COUNT_BITS  = 7
) (
   input  wire logic [TABLE_DEPTH-1:0] lt_vec,
   input  wire logic [TABLE_DEPTH-1:0] eq_vec,
   input  wire logic [TABLE_DEPTH-1:0] side_vec,
   output logic [COUNT_BITS-1:0]       rank,
   output logic                        hit,
   output logic                        hit_side
);

   logic [TABLE_DEPTH:0] boundary;

   // the less-than flags form a run from cell 0; mark where it ends
   always_comb begin
      boundary[0] = !lt_vec[0];
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         boundary[i] = lt_vec[i-1] && !lt_vec[i];
      end
      boundary[TABLE_DEPTH] = lt_vec[TABLE_DEPTH-1];
   end

   // one-hot to binary
   always_comb begin
      rank = '0;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         if (boundary[i]) begin
            rank = rank | COUNT_BITS'(i);
         end
      end
   end

   // prices are distinct, so at most one cell matches
   assign hit      = |eq_vec;
   assign hit_side = |(eq_vec & side_vec);

endmodule

`default_nettype wire

// ----- test/sorted_price_level_table_unit_tb.sv -----
// Testbench: random and directed requests against a predicted sorted price level table
`timescale 1ns / 1ps

module sorted_price_level_table_unit_tb;
   import sptu_pkg::*;

   // the unused request code, which the table treats as a lookup
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam int POOL_SIZE     = 100;
   localparam int RANDOM_ITEMS  = 1530;
   localparam int QUIET_FROM    = 2000;
   localparam int QUIET_TO      = 4500;
   localparam int TAIL_CYCLES   = 24;
   localparam int RUN_LIMIT     = 250000;

   // traffic shapes for the random phases
   typedef enum logic [1:0] {
      PHASE_GROW,
      PHASE_SHRINK,
      PHASE_CHURN
   } phase_kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] price;
      logic        side;
   } level_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] rank;
      logic       stored_side;
      logic [6:0] level_count;
   } level_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sptu_req_if req_if ();
   sptu_rsp_if rsp_if ();

   sorted_price_level_table_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow copy of the table
   logic [31:0] shadow_price [SPTU_TABLE_DEPTH];
   logic        shadow_side  [SPTU_TABLE_DEPTH];
   int          shadow_total = 0;

   level_req_type pending_items [$];
   level_rsp_type awaited_results [$];
   level_req_type awaited_reqs [$];
   level_req_type on_wire;
   logic [31:0]   price_pool [POOL_SIZE];
   int            cycle_count = 0;
   int            mismatch_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // apply one request to the shadow table and return the result it should give
   function automatic level_rsp_type level_table_apply(input level_req_type rq);
      int            r;
      int            i;
      bit            hit;
      level_rsp_type rs;
      r = 0;
      while (r < shadow_total && shadow_price[r] < rq.price)
         r++;
      hit = (r < shadow_total) && (shadow_price[r] == rq.price);
      rs.status      = hit ? STATUS_FOUND : STATUS_MISSING;
      rs.rank        = r[6:0];
      rs.stored_side = hit ? shadow_side[r] : 1'b0;
      case (rq.kind)
         KIND_CREATE: begin
            if (hit) begin
               if (shadow_side[r] != rq.side)
                  rs.status = STATUS_MISMATCH;
            end else if (shadow_total >= SPTU_TABLE_DEPTH) begin
               rs.status = STATUS_FULL;
            end else begin
               // open a slot at the rank
               for (i = shadow_total; i > r; i--) begin
                  shadow_price[i] = shadow_price[i-1];
                  shadow_side[i]  = shadow_side[i-1];
               end
               shadow_price[r] = rq.price;
               shadow_side[r]  = rq.side;
               shadow_total++;
               rs.status      = STATUS_CREATED;
               rs.stored_side = rq.side;
            end
         end
         KIND_ERASE: begin
            if (hit) begin
               // close the gap above the removed entry
               for (i = r; i + 1 < shadow_total; i++) begin
                  shadow_price[i] = shadow_price[i+1];
                  shadow_side[i]  = shadow_side[i+1];
               end
               shadow_total--;
            end
         end
         default: ;
      endcase
      rs.level_count = shadow_total[6:0];
      return rs;
   endfunction

   // random back-pressure and gaps, none inside the quiet window
   function automatic bit take_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
         return 1'b0;
      return $urandom_range(0, 99) < 36;
   endfunction

   function automatic logic [31:0] pick_price();
      if ($urandom_range(0, 99) < 85)
         return price_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   function automatic logic [1:0] pick_kind(input phase_kind_type ph);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return KIND_SPARE;
      case (ph)
         PHASE_GROW:
            return (roll < 80) ? KIND_CREATE : (roll < 90) ? KIND_ERASE : KIND_LOOKUP;
         PHASE_SHRINK:
            return (roll < 70) ? KIND_ERASE : (roll < 80) ? KIND_CREATE : KIND_LOOKUP;
         default:
            return (roll < 45) ? KIND_CREATE : (roll < 75) ? KIND_ERASE : KIND_LOOKUP;
      endcase
   endfunction

   task automatic queue_item(input logic [1:0] kind, input logic [31:0] price, input logic side);
      level_req_type it;
      it.kind  = kind;
      it.price = price;
      it.side  = side;
      pending_items.push_back(it);
   endtask

   // hold off until the table has answered everything sent so far;
   // checked at the falling edge, when the driver's updates have settled
   task automatic wait_drained();
      while (pending_items.size() != 0 || awaited_results.size() != 0 || req_if.valid)
         @(negedge clock);
   endtask

   // cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // request driver: predict on acceptance, then present the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            awaited_results.push_back(level_table_apply(on_wire));
            awaited_reqs.push_back(on_wire);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && !take_break()) begin
               on_wire = pending_items.pop_front();
               req_if.valid <= 1'b1;
               req_if.kind  <= on_wire.kind;
               req_if.price <= on_wire.price;
               req_if.side  <= on_wire.side;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      level_rsp_type got;
      level_rsp_type want;
      level_req_type src;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status      = rsp_if.status;
            got.rank        = rsp_if.rank;
            got.stored_side = rsp_if.stored_side;
            got.level_count = rsp_if.level_count;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result status %0d rank %0d side %0d count %0d",
                        $time, got.status, got.rank, got.stored_side, got.level_count);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               src  = awaited_reqs.pop_front();
               if (got !== want) begin
                  $write("%0t: kind %0d price %h side %0d: ",
                         $time, src.kind, src.price, src.side);
                  $display("exp st %0d rk %0d sd %0d cnt %0d, got st %0d rk %0d sd %0d cnt %0d",
                           want.status, want.rank, want.stored_side, want.level_count,
                           got.status, got.rank, got.stored_side, got.level_count);
                  mismatch_count++;
               end
            end
         end
         rsp_if.ready <= !take_break();
      end
   end

   // stimulus and end of run
   initial begin
      int             sent;
      int             n;
      int             span;
      phase_kind_type ph;
      req_if.valid = 1'b0;
      req_if.kind  = KIND_LOOKUP;
      req_if.price = '0;
      req_if.side  = 1'b0;
      rsp_if.ready = 1'b0;

      // price pool: both extremes, scattered, clustered, high and small values
      price_pool[0] = 32'h0000_0000;
      price_pool[1] = 32'hFFFF_FFFF;
      for (n = 2; n < POOL_SIZE; n++) begin
         case (n % 4)
            0: price_pool[n] = $urandom();
            1: price_pool[n] = 32'h0010_0000 + n;
            2: price_pool[n] = $urandom() | 32'hFFFF_0000;
            default: price_pool[n] = n * 3;
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, inserts at both ends, duplicates, side clash, lookups, spare code, erases
      queue_item(KIND_LOOKUP, 32'h0000_0000, 1'b0);
      queue_item(KIND_ERASE,  32'h0000_0005, 1'b1);
      queue_item(KIND_CREATE, 32'h0000_0100, 1'b1);
      queue_item(KIND_CREATE, 32'h0000_0000, 1'b0);
      queue_item(KIND_CREATE, 32'hFFFF_FFFF, 1'b1);
      queue_item(KIND_CREATE, 32'h0000_0100, 1'b1);
      queue_item(KIND_CREATE, 32'h0000_0100, 1'b0);
      queue_item(KIND_CREATE, 32'h5555_5555, 1'b0);
      queue_item(KIND_CREATE, 32'hAAAA_AAAA, 1'b1);
      queue_item(KIND_LOOKUP, 32'h0000_0100, 1'b0);
      queue_item(KIND_LOOKUP, 32'h0000_0080, 1'b1);
      queue_item(KIND_LOOKUP, 32'hFFFF_FFFE, 1'b0);
      queue_item(KIND_SPARE,  32'hFFFF_FFFF, 1'b1);
      queue_item(KIND_SPARE,  32'h7FFF_FFFF, 1'b0);
      queue_item(KIND_CREATE, 32'h8000_0000, 1'b0);
      queue_item(KIND_ERASE,  32'h0000_0100, 1'b0);
      queue_item(KIND_ERASE,  32'h0000_0100, 1'b1);
      queue_item(KIND_ERASE,  32'h0000_0000, 1'b1);
      queue_item(KIND_LOOKUP, 32'h5555_5555, 1'b1);
      queue_item(KIND_ERASE,  32'hFFFF_FFFF, 1'b0);
      queue_item(KIND_ERASE,  32'h5555_5555, 1'b0);
      queue_item(KIND_ERASE,  32'hAAAA_AAAA, 1'b0);
      queue_item(KIND_ERASE,  32'h8000_0000, 1'b1);
      wait_drained();

      // random phases: fill to full, drain, mixed traffic; pause between phases
      sent = 0;
      ph   = PHASE_GROW;
      while (sent < RANDOM_ITEMS) begin
         span = (ph == PHASE_GROW) ? 260 : (ph == PHASE_SHRINK) ? 220 : 170;
         for (n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
            queue_item(pick_kind(ph), pick_price(), 1'($urandom_range(0, 1)));
            sent++;
         end
         wait_drained();
         ph = (ph == PHASE_GROW) ? PHASE_SHRINK :
              (ph == PHASE_SHRINK) ? PHASE_CHURN : PHASE_GROW;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
